// ----- hdl/length_prefixed_frame_deframer_assert.svh -----
// Assertion macros shared by the deframer RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define LPFD_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define LPFD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- hdl/lpfd_pkg.sv -----
// Shared types and constants of the length-prefixed frame deframer.
// No dependencies; every other RTL file imports this package.
package lpfd_pkg;

  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);

  // Byte offsets of the header fields.
  localparam logic [HDR_CNT_W-1:0] OFS_MAIN = HDR_CNT_W'(4);
  localparam logic [HDR_CNT_W-1:0] OFS_SUB  = HDR_CNT_W'(8);
  localparam logic [HDR_CNT_W-1:0] OFS_LEN  = HDR_CNT_W'(12);
  localparam logic [HDR_CNT_W-1:0] OFS_SEQ  = HDR_CNT_W'(16);
  localparam logic [HDR_CNT_W-1:0] OFS_TS   = HDR_CNT_W'(24);
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned ADDR_W     = 3;

  localparam logic [31:0] SYNC_WORD_RESET   = 32'd0;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd3145696;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SYNC  = 2'd2,
    ST_LEN   = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] sync_word;
    logic [31:0] max_payload_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [31:0] main_type;
    logic [31:0] sub_type;
    logic [63:0] frame_sequence;
    logic [63:0] frame_timestamp;
    status_e     status;
    logic        frame_end;
  } result_t;

endpackage

// ----- hdl/lpfd_cfg_regs.sv -----
// APB-style configuration registers: sync word and maximum payload length.
// Depends on lpfd_pkg.
module lpfd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpfd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lpfd_pkg::cfg_t              cfg_o
);
  import lpfd_pkg::*;

  localparam logic REG_SYNC_WORD   = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  logic [31:0] sync_q, sync_d;
  logic [31:0] max_q, max_d;
  logic        wr_en;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_comb begin
    sync_d = sync_q;
    max_d  = max_q;
    prdata = '0;
    unique case (reg_idx)
      REG_SYNC_WORD: begin
        prdata = sync_q;
        if (wr_en) sync_d = pwdata;
      end
      REG_MAX_PAYLOAD: begin
        prdata = max_q;
        if (wr_en) max_d = pwdata;
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_WORD_RESET;
      max_q  <= MAX_PAYLOAD_RESET;
    end else begin
      sync_q <= sync_d;
      max_q  <= max_d;
    end
  end

  assign cfg_o.sync_word         = sync_q;
  assign cfg_o.max_payload_bytes = max_q;

endmodule

// ----- hdl/lpfd_core.sv -----
// Header capture, sync and length checks and payload tagging, one byte per cycle while accept_i is high.
// Depends on lpfd_pkg and length_prefixed_frame_deframer_assert.svh.
`include "length_prefixed_frame_deframer_assert.svh"

module lpfd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpfd_pkg::cfg_t    cfg_i,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  output logic              res_valid_o,
  output lpfd_pkg::result_t res_o
);
  import lpfd_pkg::*;

  localparam logic PHASE_HEADER  = 1'b0;
  localparam logic PHASE_PAYLOAD = 1'b1;

  logic                 phase_q, phase_d;
  logic [HDR_CNT_W-1:0] hcnt_q, hcnt_d;
  logic [31:0]          flag_q, flag_d;
  logic [31:0]          main_q, main_d;
  logic [31:0]          sub_q, sub_d;
  logic [63:0]          seq_q, seq_d;
  logic [63:0]          ts_q, ts_d;
  logic [31:0]          rem_q, rem_d;
  logic                 emit;
  result_t              res;

  always_comb begin
    phase_d = phase_q;
    hcnt_d  = hcnt_q;
    flag_d  = flag_q;
    main_d  = main_q;
    sub_d   = sub_q;
    seq_d   = seq_q;
    ts_d    = ts_q;
    rem_d   = rem_q;
    emit    = 1'b0;
    res     = '0;

    if (phase_q == PHASE_PAYLOAD) begin
      rem_d                = rem_q - 32'd1;
      emit                 = 1'b1;
      res.payload_byte     = data_byte_i;
      res.main_type        = main_q;
      res.sub_type         = sub_q;
      res.frame_sequence   = seq_q;
      res.frame_timestamp  = ts_q;
      res.status           = ST_DATA;
      res.frame_end        = (rem_d == 32'd0);
      if (rem_d == 32'd0) phase_d = PHASE_HEADER;
    end else begin
      // Each header byte lands in its lane of the field it belongs to.
      if (hcnt_q < OFS_MAIN) begin
        flag_d[{hcnt_q[1:0], 3'b000} +: 8] = data_byte_i;
      end else if (hcnt_q < OFS_SUB) begin
        main_d[{hcnt_q[1:0], 3'b000} +: 8] = data_byte_i;
      end else if (hcnt_q < OFS_LEN) begin
        sub_d[{hcnt_q[1:0], 3'b000} +: 8] = data_byte_i;
      end else if (hcnt_q < OFS_SEQ) begin
        rem_d[{hcnt_q[1:0], 3'b000} +: 8] = data_byte_i;
      end else if (hcnt_q < OFS_TS) begin
        seq_d[{hcnt_q[2:0], 3'b000} +: 8] = data_byte_i;
      end else begin
        ts_d[{hcnt_q[2:0], 3'b000} +: 8] = data_byte_i;
      end

      hcnt_d = hcnt_q + 1'b1;

      if ((hcnt_q == OFS_MAIN - 1'b1) && (flag_d != cfg_i.sync_word)) begin
        hcnt_d        = '0;
        emit          = 1'b1;
        res.status    = ST_SYNC;
        res.frame_end = 1'b1;
      end else if ((hcnt_q == OFS_SEQ - 1'b1) && (rem_d > cfg_i.max_payload_bytes)) begin
        hcnt_d        = '0;
        emit          = 1'b1;
        res.main_type = main_q;
        res.sub_type  = sub_q;
        res.status    = ST_LEN;
        res.frame_end = 1'b1;
      end else if (hcnt_q == HDR_LAST) begin
        hcnt_d = '0;
        if (rem_q == 32'd0) begin
          // A frame without payload still reports its header once.
          emit                = 1'b1;
          res.main_type       = main_q;
          res.sub_type        = sub_q;
          res.frame_sequence  = seq_q;
          res.frame_timestamp = ts_d;
          res.status          = ST_EMPTY;
          res.frame_end       = 1'b1;
        end else begin
          phase_d = PHASE_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_HEADER;
      hcnt_q  <= '0;
      rem_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      flag_q <= flag_d;
      main_q <= main_d;
      sub_q  <= sub_d;
      seq_q  <= seq_d;
      ts_q   <= ts_d;
    end
  end

  assign res_valid_o = accept_i && emit;
  assign res_o       = res;

  `LPFD_ASSERT_SAME(a_payload_count_idle, phase_q == PHASE_PAYLOAD, hcnt_q == '0, "header count must be zero during payload")
  `LPFD_ASSERT_SAME(a_payload_rem_nonzero, phase_q == PHASE_PAYLOAD, rem_q != 32'd0, "payload phase with nothing left to pass")
  `LPFD_ASSERT_SAME(a_sync_err_place, res_valid_o && (res_o.status == ST_SYNC), hcnt_q == OFS_MAIN - 1'b1, "sync error away from the end of the sync word")
  `LPFD_ASSERT_NEXT(a_last_byte_ends, accept_i && (phase_q == PHASE_PAYLOAD) && (rem_q == 32'd1), phase_q == PHASE_HEADER, "last payload byte did not return to header phase")

endmodule

// ----- hdl/lpfd_out_fifo.sv -----
// Small result queue that decouples the output handshake from the input.
// Depends on lpfd_pkg and length_prefixed_frame_deframer_assert.svh.
`include "length_prefixed_frame_deframer_assert.svh"

module lpfd_out_fifo #(
  parameter int unsigned Depth = lpfd_pkg::FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lpfd_pkg::result_t data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lpfd_pkg::result_t data_o
);
  import lpfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign full_o      = (count_q == CntFull);
  assign data_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    if (pop)    rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    if (push_i && !pop)      count_d = count_q + 1'b1;
    else if (pop && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  `LPFD_ASSERT_SAME(a_no_overflow, push_i, count_q != CntFull, "result pushed into a full queue")
  `LPFD_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CntFull, "queue count beyond its depth")
  `LPFD_ASSERT_NEXT(a_count_grows, push_i && !pop, count_q == $past(count_q) + 1'b1, "push without pop did not raise the count")

endmodule

// ----- hdl/length_prefixed_frame_deframer.sv -----
// Top level of the length-prefixed frame deframer.
// Depends on lpfd_pkg, lpfd_cfg_regs, lpfd_core and lpfd_out_fifo.
//
//   port group     direction  handshake               payload
//   in             to block   in_valid_i/in_stall_o   data_byte_i
//   out            from block out_valid_o/out_stall_i payload_byte_o .. frame_end_o
//   configuration  to block   psel/penable/pwrite     paddr, pwdata, prdata
//
// One byte word is accepted per cycle while in_stall_o is low; a result that a byte
// causes is written into the registered result queue when its byte is accepted.
// The header counter and field registers are updated once per accepted byte.
// Reset clears the phase, header count, byte counter and result queue.
// A result queue of FifoDepth entries (two by default) holds results while out_stall_i is high; in_stall_o
// rises only when that queue is full.
module length_prefixed_frame_deframer #(
  parameter int unsigned FifoDepth = lpfd_pkg::FIFO_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  payload_byte_o,
  output logic [31:0]                 main_type_o,
  output logic [31:0]                 sub_type_o,
  output logic [63:0]                 frame_sequence_o,
  output logic [63:0]                 frame_timestamp_o,
  output logic [1:0]                  status_o,
  output logic                        frame_end_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpfd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lpfd_pkg::*;

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    core_valid;
  logic    accept;
  logic    full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  lpfd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lpfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  lpfd_out_fifo #(
    .Depth (FifoDepth)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (core_valid),
    .data_i      (core_res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_res)
  );

  assign payload_byte_o    = out_res.payload_byte;
  assign main_type_o       = out_res.main_type;
  assign sub_type_o        = out_res.sub_type;
  assign frame_sequence_o  = out_res.frame_sequence;
  assign frame_timestamp_o = out_res.frame_timestamp;
  assign status_o          = out_res.status;
  assign frame_end_o       = out_res.frame_end;

endmodule
